// ----- hdl/usrb_pkg.sv -----
// ----------------------------------------------------------------------------
// USART register block package
// Request and response types, register offsets, function codes and the bit
// positions of the control and status registers.
// ----------------------------------------------------------------------------
package usrb_pkg;

	localparam int unsigned OFS_W = 10;

	// Function codes of a request.
	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_RX    = 2'd2;

	// Register offsets within the 1 KiB window.
	localparam logic [OFS_W-1:0] OFS_CR1  = 10'h000;
	localparam logic [OFS_W-1:0] OFS_CR2  = 10'h004;
	localparam logic [OFS_W-1:0] OFS_CR3  = 10'h008;
	localparam logic [OFS_W-1:0] OFS_BRR  = 10'h00C;
	localparam logic [OFS_W-1:0] OFS_GTPR = 10'h010;
	localparam logic [OFS_W-1:0] OFS_RTOR = 10'h014;
	localparam logic [OFS_W-1:0] OFS_RQR  = 10'h018;
	localparam logic [OFS_W-1:0] OFS_ISR  = 10'h01C;
	localparam logic [OFS_W-1:0] OFS_ICR  = 10'h020;
	localparam logic [OFS_W-1:0] OFS_RDR  = 10'h024;
	localparam logic [OFS_W-1:0] OFS_TDR  = 10'h028;

	// Control register 1 bits.
	localparam int unsigned C1_UE     = 0;
	localparam int unsigned C1_RE     = 2;
	localparam int unsigned C1_TE     = 3;
	localparam int unsigned C1_IDLEIE = 4;
	localparam int unsigned C1_RXNEIE = 5;
	localparam int unsigned C1_TCIE   = 6;
	localparam int unsigned C1_TXEIE  = 7;
	localparam int unsigned C1_PEIE   = 8;
	localparam int unsigned C1_CMIE   = 14;
	localparam int unsigned C1_RTOIE  = 26;
	localparam int unsigned C1_EOBIE  = 27;

	// Control register 2 and 3 bits.
	localparam int unsigned C2_LBDIE   = 6;
	localparam int unsigned C3_CTSIE   = 10;
	localparam int unsigned C3_WUFIE   = 22;
	localparam int unsigned C3_TCBGTIE = 24;

	// Status register bits.
	localparam int unsigned S_PE    = 0;
	localparam int unsigned S_FE    = 1;
	localparam int unsigned S_ORE   = 3;
	localparam int unsigned S_IDLE  = 4;
	localparam int unsigned S_RXNE  = 5;
	localparam int unsigned S_TC    = 6;
	localparam int unsigned S_TXE   = 7;
	localparam int unsigned S_LBDF  = 8;
	localparam int unsigned S_CTSIF = 9;
	localparam int unsigned S_RTOF  = 11;
	localparam int unsigned S_EOBF  = 12;
	localparam int unsigned S_CMF   = 17;
	localparam int unsigned S_WUF   = 20;
	localparam int unsigned S_TEACK = 21;
	localparam int unsigned S_REACK = 22;
	localparam int unsigned S_TCBGT = 25;

	localparam logic [31:0] ISR_RESET  = 32'h0000_00C0;
	// Clear bits that sit at the position of the flag they clear.
	localparam logic [31:0] ICR_DIRECT = 32'h0012_1B5F;
	localparam int unsigned ICR_TCBGTCF = 7;

	typedef struct packed {
		logic [1:0]       func;
		logic [OFS_W-1:0] reg_offset;
		logic [31:0]      write_data;
		logic [7:0]       rx_byte;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bad_offset;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        rx_accepted;
		logic        irq_level;
	} rsp_t;

endpackage

// ----- hdl/usart_register_block_core.sv -----
// ----------------------------------------------------------------------------
// USART register block core
// Takes bus reads, bus writes and received serial bytes and returns one
// response per request with read data, transmit byte and interrupt level.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while req_stall is low. A request is
// registered on entry and evaluated against the register file while it sits in
// the entry register; its response is captured in the output register when it
// advances. The register file updates when the response is registered, so the
// following request always sees the effect of the one before it. When the
// response consumer stalls, the entry register holds and req_stall rises
// once both registers are full. No clearing pass follows reset.
module usart_register_block_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  usrb_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output usrb_pkg::rsp_t rsp_data
);

	usrb_pkg::req_t req_s1;
	logic           valid_s1;
	usrb_pkg::rsp_t rsp_s2;
	logic           valid_s2;
	usrb_pkg::rsp_t rsp_next;
	logic           advance;

	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req_data;
		end
	end

	usrb_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.rsp    (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp_data  = rsp_s2;

`ifndef SYNTHESIS
	// A transmitted byte only comes from a clean write.
	a_tx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.tx_valid |->
			rsp_data.read_data == 32'd0 && !rsp_data.bad_offset && !rsp_data.rx_accepted)
		else $error("transmit response carries read or receive fields");

	// Input stall only when both stages are occupied and the output is stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && valid_s2 && rsp_stall)
		else $error("request stalled without a full pipeline");

	// A held request is neither lost nor altered.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("held request changed");
`endif

endmodule

// ----- hdl/usrb_regfile.sv -----
// ----------------------------------------------------------------------------
// USART register file
// Holds the USART registers and computes the response and the next register
// contents for one request; the registers update when step is high.
// ----------------------------------------------------------------------------
module usrb_regfile (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  usrb_pkg::req_t req,
	output usrb_pkg::rsp_t rsp
);

	logic [31:0] ctrl1_q, ctrl2_q, ctrl3_q, baud_q, gtpr_q, rtor_q, rqr_q, isr_q, tdr_q;
	logic [7:0]  rdr_q;

	logic [31:0] ctrl1_d, ctrl2_d, ctrl3_d, baud_d, gtpr_d, rtor_d, rqr_d, isr_d, tdr_d;
	logic [7:0]  rdr_d;

	logic [31:0] read_data;
	logic        bad, txv, acc;
	logic [7:0]  txb;
	logic        err_en, irq1, irq2;

	always_comb begin
		ctrl1_d   = ctrl1_q;
		ctrl2_d   = ctrl2_q;
		ctrl3_d   = ctrl3_q;
		baud_d    = baud_q;
		gtpr_d    = gtpr_q;
		rtor_d    = rtor_q;
		rqr_d     = rqr_q;
		isr_d     = isr_q;
		tdr_d     = tdr_q;
		rdr_d     = rdr_q;
		read_data = '0;
		bad       = 1'b0;
		txv       = 1'b0;
		txb       = '0;
		acc       = 1'b0;

		case (req.func)
			usrb_pkg::FUNC_READ: begin
				case (req.reg_offset)
					usrb_pkg::OFS_CR1:  read_data = ctrl1_q;
					usrb_pkg::OFS_CR2:  read_data = ctrl2_q;
					usrb_pkg::OFS_CR3:  read_data = ctrl3_q;
					usrb_pkg::OFS_BRR:  read_data = baud_q;
					usrb_pkg::OFS_GTPR: read_data = gtpr_q;
					usrb_pkg::OFS_RTOR: read_data = rtor_q;
					usrb_pkg::OFS_ISR:  read_data = isr_q;
					usrb_pkg::OFS_RDR: begin
						read_data = {24'd0, rdr_q};
						isr_d[usrb_pkg::S_RXNE] = 1'b0;
					end
					usrb_pkg::OFS_TDR:  read_data = tdr_q;
					default:            bad = 1'b1;
				endcase
			end
			usrb_pkg::FUNC_WRITE: begin
				case (req.reg_offset)
					usrb_pkg::OFS_CR1: begin
						ctrl1_d = req.write_data;
						isr_d[usrb_pkg::S_REACK] = req.write_data[usrb_pkg::C1_RE];
						isr_d[usrb_pkg::S_TEACK] = req.write_data[usrb_pkg::C1_TE];
					end
					usrb_pkg::OFS_CR2:  ctrl2_d = req.write_data;
					usrb_pkg::OFS_CR3:  ctrl3_d = req.write_data;
					usrb_pkg::OFS_BRR:  baud_d  = req.write_data;
					usrb_pkg::OFS_GTPR: gtpr_d  = req.write_data;
					usrb_pkg::OFS_RTOR: rtor_d  = req.write_data;
					usrb_pkg::OFS_RQR:  rqr_d   = req.write_data;
					usrb_pkg::OFS_ICR: begin
						isr_d = isr_q & ~(req.write_data & usrb_pkg::ICR_DIRECT);
						if (req.write_data[usrb_pkg::ICR_TCBGTCF]) begin
							isr_d[usrb_pkg::S_TCBGT] = 1'b0;
						end
					end
					usrb_pkg::OFS_TDR: begin
						tdr_d = req.write_data;
						if (ctrl1_q[usrb_pkg::C1_TE] && ctrl1_q[usrb_pkg::C1_UE]) begin
							txv = 1'b1;
							txb = req.write_data[7:0];
							isr_d[usrb_pkg::S_TXE] = 1'b1;
							isr_d[usrb_pkg::S_TC]  = 1'b1;
						end
					end
					default: bad = 1'b1;
				endcase
			end
			usrb_pkg::FUNC_RX: begin
				if (ctrl1_q[usrb_pkg::C1_RE] && ctrl1_q[usrb_pkg::C1_UE]) begin
					acc   = 1'b1;
					rdr_d = req.rx_byte;
					isr_d[usrb_pkg::S_RXNE] = 1'b1;
					isr_d[usrb_pkg::S_IDLE] = 1'b1;
					if (req.rx_byte == ctrl2_q[31:24]) begin
						isr_d[usrb_pkg::S_CMF] = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// The interrupt level is taken from the register contents after this request.
	// Overrun and framing errors share the enables of the RXNE, PE, TXE and IDLE events.
	assign err_en = ctrl1_d[usrb_pkg::C1_RXNEIE] | ctrl1_d[usrb_pkg::C1_PEIE] |
		ctrl1_d[usrb_pkg::C1_TXEIE] | ctrl1_d[usrb_pkg::C1_IDLEIE];

	assign irq1 =
		(ctrl1_d[usrb_pkg::C1_CMIE]   & isr_d[usrb_pkg::S_CMF])  |
		(ctrl1_d[usrb_pkg::C1_EOBIE]  & isr_d[usrb_pkg::S_EOBF]) |
		(ctrl1_d[usrb_pkg::C1_RTOIE]  & isr_d[usrb_pkg::S_RTOF]) |
		(ctrl1_d[usrb_pkg::C1_TXEIE]  & isr_d[usrb_pkg::S_TXE])  |
		(ctrl1_d[usrb_pkg::C1_TCIE]   & isr_d[usrb_pkg::S_TC])   |
		(ctrl1_d[usrb_pkg::C1_RXNEIE] & isr_d[usrb_pkg::S_RXNE]) |
		(ctrl1_d[usrb_pkg::C1_IDLEIE] & isr_d[usrb_pkg::S_IDLE]) |
		(err_en & (isr_d[usrb_pkg::S_ORE] | isr_d[usrb_pkg::S_FE])) |
		(ctrl1_d[usrb_pkg::C1_PEIE]   & isr_d[usrb_pkg::S_PE]);

	assign irq2 =
		(ctrl2_d[usrb_pkg::C2_LBDIE]   & isr_d[usrb_pkg::S_LBDF])  |
		(ctrl3_d[usrb_pkg::C3_TCBGTIE] & isr_d[usrb_pkg::S_TCBGT]) |
		(ctrl3_d[usrb_pkg::C3_WUFIE]   & isr_d[usrb_pkg::S_WUF])   |
		(ctrl3_d[usrb_pkg::C3_CTSIE]   & isr_d[usrb_pkg::S_CTSIF]);

	always_comb begin
		rsp.read_data   = read_data;
		rsp.bad_offset  = bad;
		rsp.tx_valid    = txv;
		rsp.tx_byte     = txb;
		rsp.rx_accepted = acc;
		rsp.irq_level   = irq1 | irq2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl1_q <= '0;
			ctrl2_q <= '0;
			ctrl3_q <= '0;
			baud_q  <= '0;
			gtpr_q  <= '0;
			rtor_q  <= '0;
			rqr_q   <= '0;
			isr_q   <= usrb_pkg::ISR_RESET;
			tdr_q   <= '0;
			rdr_q   <= '0;
		end else if (step) begin
			ctrl1_q <= ctrl1_d;
			ctrl2_q <= ctrl2_d;
			ctrl3_q <= ctrl3_d;
			baud_q  <= baud_d;
			gtpr_q  <= gtpr_d;
			rtor_q  <= rtor_d;
			rqr_q   <= rqr_d;
			isr_q   <= isr_d;
			tdr_q   <= tdr_d;
			rdr_q   <= rdr_d;
		end
	end

endmodule
